// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file vsl_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check cons in the cycle after ante
`define VSL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// check cons in the same cycle as ante
`define VSL_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// check that cond never holds
`define VSL_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/vsl_pkg.sv =====
// Types, widths and constants of the three-axis velocity slew limiter.
// No dependencies; used by every module of the block.
package vsl_pkg;

	localparam int TGT_W  = 13;
	localparam int VEL_W  = 21;
	localparam int DIFF_W = 22;
	localparam int ACC_W  = 16;
	localparam int ELAP_W = 16;
	localparam int EQ_W   = 10;
	localparam int ER_W   = 7;
	localparam int STEP_W = 31;
	localparam int S10_W  = 18;
	localparam int TS_W   = 32;
	localparam int FRAC_SH = 5;
	localparam int IN_W   = 72;
	localparam int OUT_W  = 64;

	localparam logic [ACC_W-1:0]  ACCEL_RESET     = 16'd1000;
	localparam logic [ELAP_W-1:0] ELAPSED_DEFAULT = 16'd10;
	localparam logic [ELAP_W-1:0] ELAPSED_MAX     = 16'hFFFF;
	localparam logic [ELAP_W-1:0] ELAP_DIV        = 16'd125;

	// floor(x / 125) for 16-bit x: (x * 67109) >> 23
	localparam logic [16:0] EDIV_MUL = 17'd67109;
	localparam int          EDIV_SH  = 23;
	// floor(x / 125) for 28-bit x: (x * 274877907) >> 35
	localparam logic [28:0] FDIV_MUL = 29'd274877907;
	localparam int          FDIV_SH  = 35;
	// floor(x / 25) for 22-bit x: (x * 5368710) >> 27
	localparam logic [22:0] S10_MUL = 23'd5368710;
	localparam int          S10_SH  = 27;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_STOP   = 1'b1;

	localparam logic REG_ACCEL_LINEAR = 1'b0;
	localparam logic REG_ACCEL_TURN   = 1'b1;

	typedef struct packed {
		logic gt;
		logic zero;
	} lane_stat_t;

	typedef struct packed {
		logic stop;
		logic ramp;
	} lane_ctl_t;

	function automatic logic [VEL_W-1:0] vmag(input logic [VEL_W-1:0] v);
		return v[VEL_W-1] ? VEL_W'(~v + VEL_W'(1)) : v;
	endfunction

endpackage

// ===== hdl/vsl_step.sv =====
// Step size unit: acceleration times elapsed time, scaled by 256/1000.
// Uses vsl_pkg; two stages of products plus a registered 10 ms step.
module vsl_step (
	input  logic                         clk,
	input  logic                         en_s3,
	input  logic                         en_s4,
	input  logic [vsl_pkg::ACC_W-1:0]    accel,
	input  logic [vsl_pkg::EQ_W-1:0]     eq,
	input  logic [vsl_pkg::ER_W-1:0]     er,
	output logic [vsl_pkg::STEP_W-1:0]   step,
	output logic [vsl_pkg::STEP_W-1:0]   step10
);

	localparam int PEQ_W = vsl_pkg::ACC_W + vsl_pkg::EQ_W;
	localparam int PER_W = vsl_pkg::ACC_W + vsl_pkg::ER_W;
	localparam int FX_W  = PER_W + vsl_pkg::FRAC_SH;
	localparam int FP_W  = FX_W + 29;
	localparam int FR_W  = FP_W - vsl_pkg::FDIV_SH;
	localparam int SX_W  = vsl_pkg::ACC_W + 6;
	localparam int SP_W  = SX_W + 23;

	logic [PEQ_W-1:0] peq_s3;
	logic [PER_W-1:0] per_s3;
	logic [vsl_pkg::STEP_W-1:0] step_s4;
	logic [vsl_pkg::S10_W-1:0]  step10_q;

	logic [FX_W-1:0] frac_x;
	logic [FP_W-1:0] frac_p;
	logic [FR_W-1:0] frac;
	logic [SP_W-1:0] s10_p;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			peq_s3 <= PEQ_W'(accel) * PEQ_W'(eq);
			per_s3 <= PER_W'(accel) * PER_W'(er);
		end
	end

	assign frac_x = {per_s3, vsl_pkg::FRAC_SH'(0)};
	assign frac_p = FP_W'(frac_x) * FP_W'(vsl_pkg::FDIV_MUL);
	assign frac   = frac_p[FP_W-1:vsl_pkg::FDIV_SH];

	always_ff @(posedge clk) begin
		if (en_s4) begin
			step_s4 <= vsl_pkg::STEP_W'({peq_s3, vsl_pkg::FRAC_SH'(0)})
				+ vsl_pkg::STEP_W'(frac);
		end
	end

	// 10 ms step: floor(accel * 64 / 25)
	assign s10_p = SP_W'({accel, 6'd0}) * SP_W'(vsl_pkg::S10_MUL);

	always_ff @(posedge clk) begin
		step10_q <= s10_p[vsl_pkg::S10_SH +: vsl_pkg::S10_W];
	end

	assign step   = step_s4;
	assign step10 = vsl_pkg::STEP_W'(step10_q);

endmodule

// ===== hdl/vsl_lane.sv =====
// One axis of the limiter: holds its velocity; moves it toward target or to zero.
// Uses vsl_pkg; the top level merges the status of the three lanes.
module vsl_lane (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic signed [vsl_pkg::TGT_W-1:0]   target,
	input  logic [vsl_pkg::STEP_W-1:0]         step,
	input  vsl_pkg::lane_ctl_t                 ctl,
	input  logic                               upd,
	output logic signed [vsl_pkg::VEL_W-1:0]   vel,
	output vsl_pkg::lane_stat_t                stat
);

	logic [vsl_pkg::VEL_W-1:0]  vel_q;
	logic [vsl_pkg::VEL_W-1:0]  tgt;
	logic [vsl_pkg::DIFF_W-1:0] diff;
	logic [vsl_pkg::DIFF_W-1:0] dmag;
	logic [vsl_pkg::VEL_W-1:0]  s;
	logic                       near;
	logic [vsl_pkg::VEL_W-1:0]  ramped;
	logic [vsl_pkg::VEL_W-1:0]  vel_d;

	assign tgt  = {target, 8'd0};
	assign diff = {tgt[vsl_pkg::VEL_W-1], tgt} - {vel_q[vsl_pkg::VEL_W-1], vel_q};
	assign dmag = diff[vsl_pkg::DIFF_W-1] ? vsl_pkg::DIFF_W'(~diff + vsl_pkg::DIFF_W'(1))
		: diff;
	assign near = vsl_pkg::STEP_W'(dmag) < step;
	assign s    = step[vsl_pkg::VEL_W-1:0];

	always_comb begin
		if (near)
			ramped = tgt;
		else if (diff[vsl_pkg::DIFF_W-1])
			ramped = vel_q - s;
		else if (diff != '0)
			ramped = vel_q + s;
		else
			ramped = vel_q;
	end

	always_comb begin
		if (ctl.stop)
			vel_d = '0;
		else if (ctl.ramp)
			vel_d = ramped;
		else
			vel_d = tgt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vel_q <= '0;
		else if (upd)
			vel_q <= vel_d;
	end

	assign stat.gt   = vsl_pkg::vmag(tgt) > vsl_pkg::vmag(vel_q);
	assign stat.zero = (vel_q == '0);
	assign vel       = vel_q;

endmodule

// ===== hdl/three_axis_velocity_slew_limiter.sv =====
// Three-axis velocity slew limiter: top level with elapsed-time stage, step units,
// three axis lanes and the merge. Uses vsl_pkg, vsl_step and vsl_lane.
// Each input is registered through stages s1, s2, s3 and s4, then into the lane velocities and output valid.
// One item per cycle while m_tready does not stall the output; the velocity loop closes in the last stage.
// Reset clears velocities, timestamp, autonomous flag and pipeline valids;
// both acceleration registers return to 1000.
module three_axis_velocity_slew_limiter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [vsl_pkg::ACC_W-1:0]    cfg_data,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// target_x, target_y, target_w, force_ramp, now_ms
	input  logic [vsl_pkg::IN_W-1:0]     s_tdata,
	// op
	input  logic                         s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// vel_x, vel_y, vel_w, autonomous
	output logic [vsl_pkg::OUT_W-1:0]    m_tdata
);

	typedef struct packed {
		logic                            op;
		logic [vsl_pkg::TGT_W-1:0]       tx;
		logic [vsl_pkg::TGT_W-1:0]       ty;
		logic [vsl_pkg::TGT_W-1:0]       tw;
		logic                            frc;
	} item_t;

	localparam int EP_W = vsl_pkg::ELAP_W + 17;

	logic [vsl_pkg::ACC_W-1:0] accel_lin_q;
	logic [vsl_pkg::ACC_W-1:0] accel_turn_q;
	logic [vsl_pkg::TS_W-1:0]  last_q;
	logic                      auto_q;
	logic v1_q, v2_q, v3_q, v4_q, ov_q;
	logic en1, en2, en3, en4, en5, acc_in;

	item_t in_item, item_s1, item_s2, item_s3, item_s4;
	logic [vsl_pkg::TS_W-1:0]   now;
	logic [vsl_pkg::TS_W-1:0]   dt;
	logic [vsl_pkg::ELAP_W-1:0] elapsed;
	logic [vsl_pkg::ELAP_W-1:0] elapsed_s1;
	logic [EP_W-1:0]            eprod;
	logic [vsl_pkg::EQ_W-1:0]   eq, eq_s2;
	logic [vsl_pkg::ELAP_W-1:0] erem;
	logic [vsl_pkg::ER_W-1:0]   er_s2;

	logic [vsl_pkg::STEP_W-1:0] step_lin, step_turn, s10_lin, s10_turn;
	logic [vsl_pkg::STEP_W-1:0] st_lin, st_turn;
	logic                       use_default;
	vsl_pkg::lane_ctl_t         ctl;
	vsl_pkg::lane_stat_t        stat_x, stat_y, stat_w;
	logic signed [vsl_pkg::VEL_W-1:0] vel_x, vel_y, vel_w;
	logic upd;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_lin_q  <= vsl_pkg::ACCEL_RESET;
			accel_turn_q <= vsl_pkg::ACCEL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				vsl_pkg::REG_ACCEL_LINEAR: accel_lin_q  <= cfg_data;
				vsl_pkg::REG_ACCEL_TURN:   accel_turn_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage enables: advance a stage when the next one is empty or advancing
	assign en5      = !ov_q || m_tready;
	assign en4      = !v4_q || en5;
	assign en3      = !v3_q || en4;
	assign en2      = !v2_q || en3;
	assign en1      = !v1_q || en2;
	assign s_tready = en1;
	assign acc_in   = s_tvalid && s_tready;

	assign in_item.op  = s_tuser;
	assign in_item.tx  = s_tdata[12:0];
	assign in_item.ty  = s_tdata[25:13];
	assign in_item.tw  = s_tdata[38:26];
	assign in_item.frc = s_tdata[39];
	assign now         = s_tdata[71:40];

	// elapsed time against the last update
	assign dt = now - last_q;
	always_comb begin
		if (last_q == '0 || dt == '0)
			elapsed = vsl_pkg::ELAPSED_DEFAULT;
		else if (dt > vsl_pkg::TS_W'(vsl_pkg::ELAPSED_MAX))
			elapsed = vsl_pkg::ELAPSED_MAX;
		else
			elapsed = dt[vsl_pkg::ELAP_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			last_q <= '0;
		else if (acc_in)
			last_q <= (s_tuser == vsl_pkg::OP_STOP) ? '0 : now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (en1) v1_q <= s_tvalid;
			if (en2) v2_q <= v1_q;
			if (en3) v3_q <= v2_q;
			if (en4) v4_q <= v3_q;
			if (en5) ov_q <= v4_q;
		end
	end

	// split elapsed into quotient and remainder by 125
	assign eprod = EP_W'(elapsed_s1) * EP_W'(vsl_pkg::EDIV_MUL);
	assign eq    = eprod[vsl_pkg::EDIV_SH +: vsl_pkg::EQ_W];
	assign erem  = elapsed_s1 - vsl_pkg::ELAP_W'(vsl_pkg::ELAP_W'(eq) * vsl_pkg::ELAP_DIV);

	always_ff @(posedge clk) begin
		if (en1) begin
			item_s1    <= in_item;
			elapsed_s1 <= elapsed;
		end
		if (en2) begin
			item_s2 <= item_s1;
			eq_s2   <= eq;
			er_s2   <= erem[vsl_pkg::ER_W-1:0];
		end
		if (en3) item_s3 <= item_s2;
		if (en4) item_s4 <= item_s3;
	end

	vsl_step u_step_lin (
		.clk    (clk),
		.en_s3  (en3),
		.en_s4  (en4),
		.accel  (accel_lin_q),
		.eq     (eq_s2),
		.er     (er_s2),
		.step   (step_lin),
		.step10 (s10_lin)
	);

	vsl_step u_step_turn (
		.clk    (clk),
		.en_s3  (en3),
		.en_s4  (en4),
		.accel  (accel_turn_q),
		.eq     (eq_s2),
		.er     (er_s2),
		.step   (step_turn),
		.step10 (s10_turn)
	);

	// merge lane status
	assign use_default = stat_x.zero && stat_y.zero && stat_w.zero;
	assign ctl.stop    = (item_s4.op == vsl_pkg::OP_STOP);
	assign ctl.ramp    = item_s4.frc || stat_x.gt || stat_y.gt || stat_w.gt;
	assign st_lin      = use_default ? s10_lin : step_lin;
	assign st_turn     = use_default ? s10_turn : step_turn;
	assign upd         = v4_q && en5;

	vsl_lane u_lane_x (
		.clk    (clk),
		.arst_n (arst_n),
		.target (item_s4.tx),
		.step   (st_lin),
		.ctl    (ctl),
		.upd    (upd),
		.vel    (vel_x),
		.stat   (stat_x)
	);

	vsl_lane u_lane_y (
		.clk    (clk),
		.arst_n (arst_n),
		.target (item_s4.ty),
		.step   (st_lin),
		.ctl    (ctl),
		.upd    (upd),
		.vel    (vel_y),
		.stat   (stat_y)
	);

	vsl_lane u_lane_w (
		.clk    (clk),
		.arst_n (arst_n),
		.target (item_s4.tw),
		.step   (st_turn),
		.ctl    (ctl),
		.upd    (upd),
		.vel    (vel_w),
		.stat   (stat_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			auto_q <= 1'b0;
		else if (upd && !ctl.stop && ctl.ramp)
			auto_q <= 1'b1;
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {auto_q, vel_w, vel_y, vel_x};

endmodule

// ===== hdl/vsl_checker.sv =====
// Port-level checker for the three-axis velocity slew limiter, bound to the top.
// Uses assert_macros.svh and vsl_pkg.
`include "assert_macros.svh"

module vsl_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	input  logic [vsl_pkg::OUT_W-1:0] m_tdata
);

	logic       in_xfer;
	logic       out_stall;
	logic [3:0] xfer_hist_q;

	assign in_xfer   = s_tvalid && s_tready;
	assign out_stall = m_tvalid && !m_tready;

	// shift in one bit per cycle, set when an input transfer happens
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			xfer_hist_q <= '0;
		else
			xfer_hist_q <= {xfer_hist_q[2:0], in_xfer};
	end

	`VSL_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, m_tvalid && $stable(m_tdata), "held result")
	`VSL_ASSERT_NEVER(a_auto_sticky, clk, arst_n, $fell(m_tdata[vsl_pkg::OUT_W-1]), "auto cleared")
	`VSL_ASSERT_SAME(a_reset_empty, clk, arst_n, $rose(arst_n), !m_tvalid, "valid after reset")
	`VSL_ASSERT_NEXT(a_in_to_out, clk, arst_n, !m_tvalid && !in_xfer && xfer_hist_q == '0, !m_tvalid, "stray result")

endmodule

bind three_axis_velocity_slew_limiter vsl_checker u_vsl_checker (.*);

// ===== verif/three_axis_velocity_slew_limiter_tb.sv =====
// Self-checking testbench for three_axis_velocity_slew_limiter: directed and random commands,
// random stalls on both streams, predicted velocities checked against every output transfer.
// Depends on vsl_pkg and the three_axis_velocity_slew_limiter RTL.
module three_axis_velocity_slew_limiter_tb;

	localparam int RST_CYCLES   = 9;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 60;
	localparam int IDLE_LIMIT   = 3000;

	typedef struct {
		logic               op;
		logic signed [12:0] tx;
		logic signed [12:0] ty;
		logic signed [12:0] tw;
		logic               force_ramp;
		logic [31:0]        now_ms;
	} cmd_t;

	typedef struct {
		logic signed [20:0] vx;
		logic signed [20:0] vy;
		logic signed [20:0] vw;
		logic               autonomous;
	} vel_t;

	class vel_scoreboard;
		logic [15:0]        accel_lin = vsl_pkg::ACCEL_RESET;
		logic [15:0]        accel_turn = vsl_pkg::ACCEL_RESET;
		logic signed [20:0] vel[3] = '{0, 0, 0};
		logic [31:0]        last_ms = '0;
		logic               auto_flag = 1'b0;
		vel_t               pending_vel[$];
		int                 errors = 0;
		int                 n_cmds = 0;
		int                 n_stops = 0;
		int                 n_forced = 0;
		int                 n_results = 0;

		function void set_accel(logic idx, logic [15:0] val);
			if (idx == vsl_pkg::REG_ACCEL_LINEAR)
				accel_lin = val;
			else
				accel_turn = val;
		endfunction

		function longint mag(longint v);
			return v < 0 ? -v : v;
		endfunction

		function void note_command(cmd_t c);
			logic signed [20:0] tgt[3];
			longint             step;
			longint             diff;
			longint             acc;
			logic [31:0]        elapsed;
			bit                 ramp;
			vel_t               r;
			n_cmds++;
			if (c.op == vsl_pkg::OP_STOP) begin
				n_stops++;
				vel = '{0, 0, 0};
				last_ms = '0;
			end else begin
				if (c.force_ramp)
					n_forced++;
				tgt[0] = {c.tx, 8'b0};
				tgt[1] = {c.ty, 8'b0};
				tgt[2] = {c.tw, 8'b0};
				ramp = c.force_ramp;
				for (int k = 0; k < 3; k++)
					if (mag(longint'(tgt[k])) > mag(longint'(vel[k])))
						ramp = 1'b1;
				if (!ramp) begin
					vel = tgt;
					last_ms = c.now_ms;
				end else begin
					if (last_ms == 0 || (vel[0] == 0 && vel[1] == 0 && vel[2] == 0))
						last_ms = c.now_ms;
					elapsed = c.now_ms - last_ms;
					if (elapsed > 32'(vsl_pkg::ELAPSED_MAX))
						elapsed = 32'(vsl_pkg::ELAPSED_MAX);
					if (elapsed == 0)
						elapsed = 32'(vsl_pkg::ELAPSED_DEFAULT);
					last_ms = c.now_ms;
					auto_flag = 1'b1;
					for (int k = 0; k < 3; k++) begin
						acc = (k == 2) ? longint'(accel_turn) : longint'(accel_lin);
						step = (acc * longint'(elapsed) * 256) / 1000;
						diff = longint'(tgt[k]) - longint'(vel[k]);
						if (mag(diff) < step)
							vel[k] = tgt[k];
						else if (diff > 0)
							vel[k] = 21'(longint'(vel[k]) + step);
						else if (diff < 0)
							vel[k] = 21'(longint'(vel[k]) - step);
					end
				end
			end
			r.vx = vel[0];
			r.vy = vel[1];
			r.vw = vel[2];
			r.autonomous = auto_flag;
			pending_vel.push_back(r);
		endfunction

		function void check_velocity(logic [vsl_pkg::OUT_W-1:0] d);
			vel_t e;
			n_results++;
			if (pending_vel.size() == 0) begin
				$error("unexpected result transfer: %h", d);
				errors++;
				return;
			end
			e = pending_vel.pop_front();
			if ($signed(d[20:0]) != e.vx) begin
				$error("vel_x: expected %0d, actual %0d", e.vx, $signed(d[20:0]));
				errors++;
			end
			if ($signed(d[41:21]) != e.vy) begin
				$error("vel_y: expected %0d, actual %0d", e.vy, $signed(d[41:21]));
				errors++;
			end
			if ($signed(d[62:42]) != e.vw) begin
				$error("vel_w: expected %0d, actual %0d", e.vw, $signed(d[62:42]));
				errors++;
			end
			if (d[63] != e.autonomous) begin
				$error("autonomous: expected %0d, actual %0d", e.autonomous, d[63]);
				errors++;
			end
		endfunction
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_we = 1'b0;
	logic                        cfg_index = 1'b0;
	logic [vsl_pkg::ACC_W-1:0]   cfg_data = '0;
	logic                        s_tvalid = 1'b0;
	logic                        s_tready;
	logic [vsl_pkg::IN_W-1:0]    s_tdata = '0;
	logic                        s_tuser = 1'b0;
	logic                        m_tvalid;
	logic                        m_tready = 1'b0;
	logic [vsl_pkg::OUT_W-1:0]   m_tdata;

	vel_scoreboard      sb = new();
	bit                 rx_stalls = 1'b1;
	bit                 rx_hold_req = 1'b0;
	logic signed [12:0] hold_tgt[3] = '{0, 0, 0};
	int                 hold_left = 0;
	logic [31:0]        clock_ms = 32'd1;
	int                 n_settings = 1;

	three_axis_velocity_slew_limiter dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_velocity(m_tdata);
	end

	function automatic int pick_gap(bit idle);
		int r;
		r = $urandom_range(0, 99);
		if (!idle || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic cmd_t mk(logic op, logic signed [12:0] tx, logic signed [12:0] ty,
			logic signed [12:0] tw, logic fr, logic [31:0] now_ms);
		cmd_t c;
		c.op = op;
		c.tx = tx;
		c.ty = ty;
		c.tw = tw;
		c.force_ramp = fr;
		c.now_ms = now_ms;
		return c;
	endfunction

	function automatic logic signed [12:0] pick_target();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 13'($urandom);
			4, 5: return 13'($signed($urandom_range(0, 127)) - 64);
			6: return '0;
			7: return 13'sd4095;
			8: return 13'sh1000;
			default: return 13'($signed($urandom_range(0, 31)) - 16);
		endcase
	endfunction

	task automatic send_cmd(cmd_t c, int gap);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {c.now_ms, c.force_ramp, c.tw, c.ty, c.tx};
		s_tuser <= c.op;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_command(c);
	endtask

	task automatic end_burst();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic wait_drain();
		while (sb.pending_vel.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_accel(logic idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_accel(idx, val);
	endtask

	task automatic run_random(int n, bit idle);
		cmd_t c;
		int   r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 4) begin
				c = mk(vsl_pkg::OP_STOP, 13'($urandom), 13'($urandom), 13'($urandom),
					1'($urandom), $urandom);
			end else begin
				if (hold_left == 0) begin
					foreach (hold_tgt[k])
						hold_tgt[k] = pick_target();
					hold_left = $urandom_range(1, 40);
				end
				hold_left--;
				r = $urandom_range(0, 99);
				if (r < 75)
					clock_ms += $urandom_range(1, 30);
				else if (r < 82)
					clock_ms = clock_ms;
				else if (r < 88)
					clock_ms += $urandom_range(100, 70000);
				else if (r < 92)
					clock_ms -= $urandom_range(1, 1000);
				else if (r < 96)
					clock_ms = $urandom;
				else
					clock_ms = '0;
				c = mk(vsl_pkg::OP_UPDATE, hold_tgt[0], hold_tgt[1], hold_tgt[2],
					$urandom_range(0, 3) == 0, clock_ms);
				if ($urandom_range(0, 9) == 0) begin
					c.tx = 13'($urandom);
					c.ty = 13'($urandom);
					c.tw = 13'($urandom);
				end
			end
			send_cmd(c, pick_gap(idle));
		end
		end_burst();
	endtask

	task automatic run_directed();
		cmd_t dir[$];
		dir.push_back(mk(vsl_pkg::OP_UPDATE, 0, 0, 0, 0, 32'd0));
		dir.push_back(mk(vsl_pkg::OP_UPDATE, 4095, -4096, 1, 0, 32'd100));
		dir.push_back(mk(vsl_pkg::OP_UPDATE, 4095, -4096, 1, 0, 32'd100));
		dir.push_back(mk(vsl_pkg::OP_UPDATE, 4095, -4096, 1, 0, 32'd150));
		dir.push_back(mk(vsl_pkg::OP_UPDATE, 4095, -4096, 1, 0, 32'd50));
		dir.push_back(mk(vsl_pkg::OP_UPDATE, 4095, -4096, -1, 0, 32'hFFFF_FFFF));
		dir.push_back(mk(vsl_pkg::OP_UPDATE, 0, 0, 0, 0, 32'd9));
		dir.push_back(mk(vsl_pkg::OP_UPDATE, -4096, 4095, -4096, 0, 32'd20));
		dir.push_back(mk(vsl_pkg::OP_UPDATE, -4096, 4095, -4096, 0, 32'd65600));
		dir.push_back(mk(vsl_pkg::OP_UPDATE, 1, 1, 1, 1, 32'd65640));
		dir.push_back(mk(vsl_pkg::OP_UPDATE, 0, 0, 0, 0, 32'd65650));
		dir.push_back(mk(vsl_pkg::OP_STOP, -1, -1, -1, 1, 32'hFFFF_FFFF));
		dir.push_back(mk(vsl_pkg::OP_UPDATE, 3, -3, 2, 0, 32'd1000));
		dir.push_back(mk(vsl_pkg::OP_UPDATE, 3, -3, 2, 0, 32'd1010));
		dir.push_back(mk(vsl_pkg::OP_UPDATE, 0, 0, 0, 0, 32'd0));
		dir.push_back(mk(vsl_pkg::OP_UPDATE, 4095, 4095, 4095, 1, 32'h8000_0000));
		dir.push_back(mk(vsl_pkg::OP_UPDATE, 4095, 4095, 4095, 0, 32'h8001_0004));
		dir.push_back(mk(vsl_pkg::OP_UPDATE, -4096, -4096, -4096, 0, 32'h8001_0005));
		dir.push_back(mk(vsl_pkg::OP_UPDATE, -4096, -4096, 100, 0, 32'h8001_0105));
		dir.push_back(mk(vsl_pkg::OP_UPDATE, 5, -5, 0, 1, 32'h8001_0106));
		dir.push_back(mk(vsl_pkg::OP_UPDATE, 5, -5, 0, 0, 32'h8001_0200));
		dir.push_back(mk(vsl_pkg::OP_STOP, 0, 0, 0, 0, 32'd0));
		dir.push_back(mk(vsl_pkg::OP_UPDATE, 2730, -1366, 1365, 1, 32'h5555_5555));
		dir.push_back(mk(vsl_pkg::OP_UPDATE, -2731, 1365, -1366, 0, 32'hAAAA_AAAA));
		foreach (dir[i])
			send_cmd(dir[i], pick_gap(1'b1));
		end_burst();
	endtask

	initial begin
		int len;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				rx_hold_req = 1'b0;
			end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
				m_tready <= 1'b0;
				repeat (len - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("three_axis_velocity_slew_limiter_tb: FAIL");
		$finish;
	end

	initial begin
		logic [15:0] lin_set[8];
		logic [15:0] turn_set[8];
		lin_set = '{16'd0, 16'd65535, 16'd1, 16'd65535, 16'd5000, 16'd0, 16'd1000, 16'd0};
		turn_set = '{16'd0, 16'd65535, 16'd65535, 16'd1, 16'd3000, 16'd0, 16'd1000, 16'd0};
		lin_set[5] = 16'($urandom);
		turn_set[5] = 16'($urandom);
		lin_set[7] = 16'($urandom_range(0, 4000));
		turn_set[7] = 16'($urandom_range(0, 4000));
		repeat (RST_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		run_directed();
		wait_drain();
		run_random(240, 1'b1);
		wait_drain();
		for (int p = 0; p < 8; p++) begin
			write_accel(vsl_pkg::REG_ACCEL_LINEAR, lin_set[p]);
			write_accel(vsl_pkg::REG_ACCEL_TURN, turn_set[p]);
			n_settings++;
			if (p == 2) begin
				rx_hold_req = 1'b1;
				run_random(24, 1'b0);
				wait_drain();
			end
			rx_stalls = (p != 4);
			run_random(p == 4 ? 200 : 210, p != 4);
			wait_drain();
		end

		$display("covered %0d commands (%0d stops, %0d forced ramps), %0d results",
			sb.n_cmds, sb.n_stops, sb.n_forced, sb.n_results);
		$display("across %0d acceleration settings with random stalls on both streams",
			n_settings);
		if (sb.errors == 0 && sb.pending_vel.size() == 0)
			$display("three_axis_velocity_slew_limiter_tb: PASS");
		else
			$display("three_axis_velocity_slew_limiter_tb: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/vsl_pkg.sv
hdl/vsl_step.sv
hdl/vsl_lane.sv
hdl/three_axis_velocity_slew_limiter.sv
hdl/vsl_checker.sv
verif/three_axis_velocity_slew_limiter_tb.sv
